// File: rtl/core/qrr_pkg.sv
package qrr_pkg;

  localparam int COEF_W = 16;
  localparam int ROOT_W = 17;
  localparam int E_W    = 2 * COEF_W;     // discriminant quarter, unsigned
  localparam int T_W    = COEF_W;         // integer square root
  localparam int R_W    = COEF_W + 2;     // square root remainder
  localparam int N_W    = COEF_W + 3;     // signed numerator
  localparam int M_W    = COEF_W + 2;     // numerator magnitude / quotient
  localparam int D_W    = COEF_W + 1;     // divisor |2a|
  localparam int SAT_W  = (M_W + 1 > ROOT_W + 1) ? M_W + 1 : ROOT_W + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_A_ZERO   = 2'd1;
  localparam logic [1:0] ST_NEG_DISC = 2'd2;

  localparam logic signed [SAT_W-1:0] ROOT_MAX = SAT_W'((64'sd1 <<< (ROOT_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] ROOT_MIN = SAT_W'(-(64'sd1 <<< (ROOT_W - 1)));

  typedef struct packed {
    logic                     vld;
    logic [E_W-1:0]           x;
    logic [R_W-1:0]           rem;
    logic [T_W-1:0]           root;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic                     par;
    logic [1:0]               status;
  } sqrt_word_t;

  typedef struct packed {
    logic           vld;
    logic [M_W-1:0] mp;
    logic [M_W-1:0] mm;
    logic [D_W-1:0] remp;
    logic [D_W-1:0] remm;
    logic [D_W-1:0] dv;
    logic           negp;
    logic           negm;
    logic [1:0]     status;
  } div_word_t;

  function automatic logic [ROOT_W-1:0] sat_root(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = v;
    if (v > ROOT_MAX) r = ROOT_MAX;
    if (v < ROOT_MIN) r = ROOT_MIN;
    return r[ROOT_W-1:0];
  endfunction

endpackage

// File: rtl/core/qrr_sqrt_cell.sv
module qrr_sqrt_cell import qrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  sqrt_word_t word_in,
  output sqrt_word_t word_out
);

  logic [R_W+1:0] rem2;
  logic [R_W+1:0] trial;
  logic [R_W+1:0] diff;
  logic           ge;
  sqrt_word_t     word_next;

  // One result bit per cell: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem2  = {word_in.rem, word_in.x[E_W-1 -: 2]};
    trial = {2'b00, word_in.root, 2'b01};
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
    word_next      = word_in;
    word_next.x    = {word_in.x[E_W-3:0], 2'b00};
    word_next.rem  = ge ? diff[R_W-1:0] : rem2[R_W-1:0];
    word_next.root = {word_in.root[T_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else if (en) begin
      word_out <= word_next;
    end
  end

endmodule

// File: rtl/core/qrr_div_cell.sv
module qrr_div_cell import qrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_word_t word_in,
  output div_word_t word_out
);

  logic [D_W:0] r2p;
  logic [D_W:0] r2m;
  logic [D_W:0] dp;
  logic [D_W:0] dm;
  logic         gep;
  logic         gem;
  div_word_t    word_next;

  // Restoring divide, one quotient bit per cell for each lane; the quotient
  // shifts in where the dividend bits leave.
  always_comb begin
    r2p = {word_in.remp, word_in.mp[M_W-1]};
    r2m = {word_in.remm, word_in.mm[M_W-1]};
    gep = (r2p >= {1'b0, word_in.dv});
    gem = (r2m >= {1'b0, word_in.dv});
    dp  = r2p - {1'b0, word_in.dv};
    dm  = r2m - {1'b0, word_in.dv};
    word_next      = word_in;
    word_next.remp = gep ? dp[D_W-1:0] : r2p[D_W-1:0];
    word_next.remm = gem ? dm[D_W-1:0] : r2m[D_W-1:0];
    word_next.mp   = {word_in.mp[M_W-2:0], gep};
    word_next.mm   = {word_in.mm[M_W-2:0], gem};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else if (en) begin
      word_out <= word_next;
    end
  end

endmodule

// File: rtl/core/quadratic_real_roots_core.sv
// Real roots of a*x^2 + b*x + c with signed integer coefficients.
//
// Input channel: in_valid / in_stall carry one coefficient set (coef_a,
// coef_b, coef_c) per transaction. Output channel: out_valid / out_stall
// carry root_plus, root_minus and status per transaction, one result for
// every input transaction, in order.
//
// status 0: both roots valid, each the exact root truncated toward zero.
// status 1: a is zero; status 2: discriminant negative. Roots read 0 then.
//
// The path runs through two product/discriminant stages, a chain of
// one-bit square root cells, two numerator stages, a chain of one-bit
// divide cells (both roots in parallel lanes) and the output register.
// Throughput is one transaction per cycle while the output is not
// stalled; the cell chains then carry a new set every cycle.
//
// Reset clears every stage valid and the output valid. When the receiver
// stalls a full output register, the whole pipeline holds and in_stall
// rises in the same cycle; every stage advances again once it drops.
module quadratic_real_roots_core import qrr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ROOT_W-1:0] root_plus,
  output logic signed [ROOT_W-1:0] root_minus,
  output logic [1:0]               status
);

  // Global advance: hold everything while a finished result waits.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // Stage 1: products. b = 2q + p, so D = 4e + p with e = q*(q+p) - a*c.
  // ---------------------------------------------------------------------
  logic signed [COEF_W-1:0]   q_in;
  logic signed [COEF_W-1:0]   qp_in;
  logic                       s1_vld;
  logic signed [COEF_W-1:0]   s1_a;
  logic signed [COEF_W-1:0]   s1_b;
  logic signed [2*COEF_W-1:0] s1_qq;
  logic signed [2*COEF_W-1:0] s1_ac;

  assign q_in  = coef_b >>> 1;
  assign qp_in = q_in + COEF_W'(signed'({1'b0, coef_b[0]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a  <= coef_a;
      s1_b  <= coef_b;
      s1_qq <= q_in * qp_in;
      s1_ac <= coef_a * coef_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: quarter discriminant, status, load the square root chain.
  // ---------------------------------------------------------------------
  logic signed [2*COEF_W:0] e_val;
  sqrt_word_t               sq [0:T_W];
  sqrt_word_t               sq_load;

  always_comb begin
    e_val          = (2*COEF_W+1)'(s1_qq) - (2*COEF_W+1)'(s1_ac);
    sq_load.vld    = s1_vld;
    sq_load.x      = e_val[E_W-1:0];
    sq_load.rem    = '0;
    sq_load.root   = '0;
    sq_load.a      = s1_a;
    sq_load.b      = s1_b;
    sq_load.par    = s1_b[0];
    if (s1_a == '0) begin
      sq_load.status = ST_A_ZERO;
    end else if (e_val[2*COEF_W]) begin
      sq_load.status = ST_NEG_DISC;
    end else begin
      sq_load.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].vld <= 1'b0;
    end else if (en) begin
      sq[0] <= sq_load;
    end
  end

  for (genvar i = 0; i < T_W; i++) begin : g_sqrt
    qrr_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .word_in  (sq[i]),
      .word_out (sq[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage A: s = floor-style root of D, exactness, signed numerators.
  // ---------------------------------------------------------------------
  sqrt_word_t               sq_end;
  logic                     rem_gt;
  logic                     exact_w;
  logic [T_W:0]             s_w;
  logic signed [N_W-1:0]    nb_w;
  logic                     sa_vld;
  logic                     sa_exact;
  logic signed [N_W-1:0]    sa_np;
  logic signed [N_W-1:0]    sa_nm;
  logic signed [COEF_W-1:0] sa_a;
  logic [1:0]               sa_status;

  assign sq_end = sq[T_W];

  always_comb begin
    rem_gt  = (sq_end.rem > R_W'(sq_end.root));
    exact_w = sq_end.par ? (sq_end.rem == R_W'(sq_end.root)) : (sq_end.rem == '0);
    s_w     = {sq_end.root, (sq_end.par | rem_gt)};
    nb_w    = -N_W'(sq_end.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else if (en) begin
      sa_vld <= sq_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_exact  <= exact_w;
      sa_np     <= nb_w + N_W'(s_w);
      sa_nm     <= nb_w - N_W'(s_w) - N_W'(!exact_w);
      sa_a      <= sq_end.a;
      sa_status <= sq_end.status;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: fold the truncation rule into a magnitude and a sign.
  // Exact: sign(n) xor sign(d), |n|. Irrational: flip n for negative d,
  // then a negative numerator loses one before the divide.
  // ---------------------------------------------------------------------
  logic                  dneg;
  logic [COEF_W-1:0]     abs_a;
  logic signed [N_W-1:0] fp;
  logic signed [N_W-1:0] fm;
  logic [N_W-1:0]        magp;
  logic [N_W-1:0]        magm;
  logic                  negp_w;
  logic                  negm_w;
  div_word_t             dw [0:M_W];
  div_word_t             dw_load;

  always_comb begin
    dneg  = sa_a[COEF_W-1];
    abs_a = dneg ? COEF_W'(-sa_a) : COEF_W'(sa_a);
    if (sa_exact) begin
      negp_w = sa_np[N_W-1] ^ dneg;
      negm_w = sa_nm[N_W-1] ^ dneg;
      fp     = sa_np;
      fm     = sa_nm;
      magp   = sa_np[N_W-1] ? N_W'(-sa_np) : N_W'(sa_np);
      magm   = sa_nm[N_W-1] ? N_W'(-sa_nm) : N_W'(sa_nm);
    end else begin
      fp     = dneg ? ~sa_np : sa_np;
      fm     = dneg ? ~sa_nm : sa_nm;
      negp_w = fp[N_W-1];
      negm_w = fm[N_W-1];
      magp   = negp_w ? N_W'(~fp) : N_W'(fp);
      magm   = negm_w ? N_W'(~fm) : N_W'(fm);
    end
    dw_load.vld    = sa_vld;
    dw_load.mp     = magp[M_W-1:0];
    dw_load.mm     = magm[M_W-1:0];
    dw_load.remp   = '0;
    dw_load.remm   = '0;
    dw_load.dv     = {abs_a, 1'b0};
    dw_load.negp   = negp_w;
    dw_load.negm   = negm_w;
    dw_load.status = sa_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dw[0].vld <= 1'b0;
    end else if (en) begin
      dw[0] <= dw_load;
    end
  end

  for (genvar j = 0; j < M_W; j++) begin : g_div
    qrr_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .word_in  (dw[j]),
      .word_out (dw[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: apply signs, saturate, zero the roots on a status.
  // ---------------------------------------------------------------------
  div_word_t              dw_end;
  logic signed [M_W:0]    qp_s;
  logic signed [M_W:0]    qm_s;
  logic [ROOT_W-1:0]      rp_w;
  logic [ROOT_W-1:0]      rm_w;

  assign dw_end = dw[M_W];

  always_comb begin
    qp_s = dw_end.negp ? -signed'({1'b0, dw_end.mp}) : signed'({1'b0, dw_end.mp});
    qm_s = dw_end.negm ? -signed'({1'b0, dw_end.mm}) : signed'({1'b0, dw_end.mm});
    rp_w = sat_root(SAT_W'(qp_s));
    rm_w = sat_root(SAT_W'(qm_s));
    if (dw_end.status != ST_OK) begin
      rp_w = '0;
      rm_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dw_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_plus  <= rp_w;
      root_minus <= rm_w;
      status     <= dw_end.status;
    end
  end

`ifndef SYNTH
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> root_plus == '0 && root_minus == '0)
    else $error("roots not zero with a nonzero status");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_end.vld && sq_end.status == ST_OK |-> sq_end.rem <= R_W'({sq_end.root, 1'b0}))
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dw_end.vld && dw_end.status == ST_OK |-> dw_end.remp < dw_end.dv && dw_end.remm < dw_end.dv)
    else $error("divide remainder not below divisor");
`endif

endmodule

// File: tb/sv/tb_quadratic_real_roots_core.sv
module tb_quadratic_real_roots_core import qrr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // One coefficient set and one root result as they cross the ports.
  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_set_t;

  typedef struct {
    logic signed [ROOT_W-1:0] rp;
    logic signed [ROOT_W-1:0] rm;
    logic [1:0]               st;
  } root_set_t;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 60;    // a little past the pipeline depth
  localparam int  LONG_HOLD   = 250;   // receiver hold-off, longer than the pipe
  localparam int  HOLD_AT     = 300;   // result count at which the hold starts

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [COEF_W-1:0] coef_a = '0;
  logic signed [COEF_W-1:0] coef_b = '0;
  logic signed [COEF_W-1:0] coef_c = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ROOT_W-1:0] root_plus;
  logic signed [ROOT_W-1:0] root_minus;
  logic [1:0]               status;

  coef_set_t pending_sets[$];
  root_set_t expected_roots[$];

  int send_idle_pct = 33;
  int recv_idle_pct = 66;
  int mismatch_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  quadratic_real_roots_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .coef_c     (coef_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .root_plus  (root_plus),
    .root_minus (root_minus),
    .status     (status)
  );

  always #1 clk = ~clk;

  // Integer square root, floor, by the bit-pair method.
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // Truncate x/d toward zero where x lies strictly inside (n, n+1).
  function automatic longint trunc_between(input longint n, input longint d);
    longint r;
    if (d < 0) begin
      n = -n - 1;
      d = -d;
    end
    r = floor_quot(n, d);
    if (n < 0) r = r + 1;
    return r;
  endfunction

  function automatic logic signed [ROOT_W-1:0] clamp_root(input longint r);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ROOT_W - 1)) - 1;
    lo = -(longint'(1) <<< (ROOT_W - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[ROOT_W-1:0];
  endfunction

  // Exact roots truncated toward zero. Split b = 2q + p so the discriminant
  // is 4e + p and its square root stays exact in integers.
  function automatic root_set_t solve_quadratic(input coef_set_t cs);
    root_set_t       res;
    longint          a, b, c, p, q, e, s, d, rp, rm;
    longint unsigned t;
    bit              exact;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    res.rp = '0;
    res.rm = '0;
    res.st = ST_OK;
    if (a == 0) begin
      res.st = ST_A_ZERO;
      return res;
    end
    p = b & 1;
    q = (b - p) / 2;
    e = q * q + p * q - a * c;
    if (e < 0) begin
      res.st = ST_NEG_DISC;
      return res;
    end
    t = isqrt(e);
    if (p == 0) begin
      s = (t * t + t < e) ? 2 * t + 1 : 2 * t;
      exact = (t * t == e);
    end else begin
      s = 2 * t + 1;
      exact = (t * t + t == e);
    end
    d = 2 * a;
    if (exact) begin
      rp = (-b + s) / d;
      rm = (-b - s) / d;
    end else begin
      rp = trunc_between(-b + s, d);
      rm = trunc_between(-b - s - 1, d);
    end
    res.rp = clamp_root(rp);
    res.rm = clamp_root(rm);
    return res;
  endfunction

  function automatic coef_set_t make_set(input int a, input int b, input int c);
    coef_set_t cs;
    cs.a = a[COEF_W-1:0];
    cs.b = b[COEF_W-1:0];
    cs.c = c[COEF_W-1:0];
    return cs;
  endfunction

  // Random set: 45 in 100 built close to chosen integer roots, with b and c
  // nudged by up to two either way; the rest noise of every kind.
  function automatic coef_set_t random_set();
    int        kind, a, r1, r2, b, c;
    coef_set_t cs;
    kind = $urandom_range(99);
    if (kind < 45) begin
      a = $urandom_range(1, 40);
      if ($urandom_range(1)) a = -a;
      r1 = int'($urandom_range(60)) - 30;
      r2 = int'($urandom_range(60)) - 30;
      b = -a * (r1 + r2) + int'($urandom_range(4)) - 2;
      c = a * r1 * r2 + int'($urandom_range(4)) - 2;
      cs = make_set(a, b, c);
    end else if (kind < 55) begin
      // large b with small a and c: wide roots, positive discriminant
      cs = make_set(int'($urandom_range(7)) - 3, $urandom, int'($urandom_range(200)) - 100);
      if (cs.a == 0) cs.a = 1;
    end else if (kind < 62) begin
      cs = make_set(0, $urandom, $urandom);
    end else if (kind < 75) begin
      cs = make_set(int'($urandom_range(30)) - 15, int'($urandom_range(60)) - 30,
                    int'($urandom_range(30)) - 15);
    end else begin
      cs = make_set($urandom, $urandom, $urandom);
    end
    return cs;
  endfunction

  // Driver: present the next pending set; hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_roots.push_back(solve_quadratic('{coef_a, coef_b, coef_c}));
      if (!(in_valid && in_stall)) begin
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          coef_set_t nxt;
          nxt = pending_sets.pop_front();
          coef_a   <= nxt.a;
          coef_b   <= nxt.b;
          coef_c   <= nxt.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted transaction against the oldest expectation,
  // and drive the receiver stall, with one long hold-off to fill the pipe.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        if (expected_roots.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected result rp=%0d rm=%0d st=%0d",
                     root_plus, root_minus, status);
        end else begin
          root_set_t exp_r;
          exp_r = expected_roots.pop_front();
          if (exp_r.rp !== root_plus || exp_r.rm !== root_minus || exp_r.st !== status) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("ERROR: expected rp=%0d rm=%0d st=%0d, got rp=%0d rm=%0d st=%0d",
                       exp_r.rp, exp_r.rm, exp_r.st, root_plus, root_minus, status);
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: advance the cycle count and stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL quadratic_real_roots_core");
      $finish;
    end
  end

  task automatic run_phase(input int s_pct, input int r_pct, input int count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) pending_sets.push_back(random_set());
    while (pending_sets.size() > 0 || expected_roots.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: field extremes, a zero, negative, zero and positive discriminant
    pending_sets.push_back(make_set(-32768, -32768, -32768));
    pending_sets.push_back(make_set(32767, 32767, 32767));
    pending_sets.push_back(make_set(-32768, 32767, 32767));
    pending_sets.push_back(make_set(32767, -32768, -32768));
    pending_sets.push_back(make_set(1, -32768, 0));
    pending_sets.push_back(make_set(-1, 32767, 0));
    pending_sets.push_back(make_set(1, -32768, -32768));
    pending_sets.push_back(make_set(0, 0, 0));
    pending_sets.push_back(make_set(0, 5, -7));
    pending_sets.push_back(make_set(0, -32768, 32767));
    pending_sets.push_back(make_set(1, 0, 1));
    pending_sets.push_back(make_set(-3, 1, -5));
    pending_sets.push_back(make_set(1, 2, 1));
    pending_sets.push_back(make_set(-1, 2, -1));
    pending_sets.push_back(make_set(4, 4, 1));
    pending_sets.push_back(make_set(9, -12, 4));
    pending_sets.push_back(make_set(1, 0, 0));
    pending_sets.push_back(make_set(3, -7, 2));
    pending_sets.push_back(make_set(-2, 3, 5));
    pending_sets.push_back(make_set(1, 0, -2));
    pending_sets.push_back(make_set(-7, -1, 3));
    pending_sets.push_back(make_set(1, 1, -1));
    run_phase(33, 66, 330);
    run_phase(66, 33, 350);
    run_phase(0, 0, 350);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("PASS quadratic_real_roots_core");
    end else begin
      $display("FAIL quadratic_real_roots_core");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/qrr_pkg.sv
rtl/core/qrr_sqrt_cell.sv
rtl/core/qrr_div_cell.sv
rtl/core/quadratic_real_roots_core.sv
tb/sv/tb_quadratic_real_roots_core.sv
